[rtl/aci_pkg.sv]
// ----------------------------------------------------------------------------
// aci_pkg
// Shared widths, breakpoint and coefficient tables and saturation for the
// aerodynamic coefficient table interpolator.
// ----------------------------------------------------------------------------
package aci_pkg;

  localparam int NUM_POINTS = 5;
  localparam int IDX_W      = $clog2(NUM_POINTS);

  localparam int MACH_W   = 16;   // unsigned Q2.14
  localparam int ALPHA_W  = 16;   // signed Q4.12
  localparam int OUT_W    = 24;   // signed Q4.20
  localparam int COEF_W   = 24;   // signed Q4.20 table entries
  localparam int RECIP_W  = 22;   // round(2^32 / segment width)
  localparam int T_W      = 17;   // segment fraction, 0 .. 65536
  localparam int SAT_IN_W = 40;

  localparam int NUM_TABLES = 5;
  localparam int TAB_CX0    = 0;
  localparam int TAB_CXA2   = 1;
  localparam int TAB_CYA    = 2;
  localparam int TAB_MZ     = 3;
  localparam int TAB_TRIM   = 4;

  typedef logic        [MACH_W-1:0]  mach_t;
  typedef logic signed [ALPHA_W-1:0] alpha_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [OUT_W-1:0]   coef_out_t;
  typedef logic        [RECIP_W-1:0] recip_t;
  typedef logic        [IDX_W-1:0]   idx_t;

  localparam mach_t BP_TAB [NUM_POINTS] = '{
    16'd9830, 16'd13107, 16'd14746, 16'd16384, 16'd18022
  };

  localparam recip_t RECIP_TAB [NUM_POINTS-1] = '{
    22'd1310640, 22'd2620480, 22'd2622080, 22'd2622080
  };

  localparam coef_t COEF_TAB [NUM_TABLES][NUM_POINTS] = '{
    '{24'sd156678, 24'sd165193, 24'sd179726, 24'sd302325, 24'sd359787},
    '{24'sd1950, 24'sd1992, 24'sd2013, 24'sd2097, 24'sd2192},
    '{24'sd73159, 24'sd72855, 24'sd72698, 24'sd74596, 24'sd77878},
    '{-24'sd138727, -24'sd138727, -24'sd138622, -24'sd160537, -24'sd159908},
    '{-24'sd1216348, -24'sd1226834, -24'sd1258291, -24'sd1310720, -24'sd1226834}
  };

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = SAT_IN_W'(2**(OUT_W-1) - 1);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = SAT_IN_W'(-(2**(OUT_W-1)));

  function automatic coef_out_t sat_out(input logic signed [SAT_IN_W-1:0] v);
    coef_out_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[OUT_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/aci_query_if.sv]
// ----------------------------------------------------------------------------
// aci_query_if
// Query channel: Mach number and angle of attack with valid/ready.
// ----------------------------------------------------------------------------
interface aci_query_if;
  logic             valid;
  logic             ready;
  aci_pkg::mach_t   mach;
  aci_pkg::alpha_t  attack_angle;

  modport source (output valid, output mach, output attack_angle, input ready);
  modport sink   (input valid, input mach, input attack_angle, output ready);
endinterface

[rtl/aci_result_if.sv]
// ----------------------------------------------------------------------------
// aci_result_if
// Result channel: four interpolated coefficients with valid/ready.
// ----------------------------------------------------------------------------
interface aci_result_if;
  logic                valid;
  logic                ready;
  aci_pkg::coef_out_t  drag_coeff;
  aci_pkg::coef_out_t  lift_coeff;
  aci_pkg::coef_out_t  moment_coeff;
  aci_pkg::coef_out_t  trim_ratio;

  modport source (output valid, output drag_coeff, output lift_coeff,
                  output moment_coeff, output trim_ratio, input ready);
  modport sink   (input valid, input drag_coeff, input lift_coeff,
                  input moment_coeff, input trim_ratio, output ready);
endinterface

[rtl/aero_coeff_table_interpolator.sv]
// ----------------------------------------------------------------------------
// aero_coeff_table_interpolator
// Piecewise linear Mach table lookup producing drag, lift, moment and trim
// coefficients from a Mach number and an angle of attack.
// ----------------------------------------------------------------------------
// A query is taken every clock cycle unless the pipeline is stalled; its
// result passes through five register stages to the result channel:
// segment search, segment fraction and alpha squared, table interpolation,
// coefficient products, then rounding and saturation into the output
// register. Each stage holds its beat only while the stage after it is full
// and stalled, so bubbles close up and queries keep entering while a result
// waits to be taken. Outside the breakpoint range the end values are held;
// at a shared breakpoint the lower segment is used. All outputs saturate to
// signed Q4.20.
module aero_coeff_table_interpolator (
  input  logic                 clk,
  input  logic                 rst,
  aci_query_if.sink            query,
  aci_result_if.source         result
);
  import aci_pkg::*;

  localparam int LERP_W = COEF_W + 1;
  localparam int TP_W   = MACH_W + RECIP_W;
  localparam int ASQ_W  = 2 * ALPHA_W;
  localparam int LP_W   = LERP_W + T_W + 1;
  localparam int DP_W   = LERP_W + ASQ_W;
  localparam int LF_W   = LERP_W + ALPHA_W;

  localparam logic        [TP_W:0]   T_HALF     = (TP_W+1)'(2**15);
  localparam logic signed [LP_W-1:0] LERP_HALF  = LP_W'(2**15);
  localparam logic signed [DP_W-1:0] DRAG_HALF  = DP_W'(2**23);
  localparam logic signed [LF_W-1:0] LIFT_HALF  = LF_W'(2**11);

  // stage ready chain
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !result.valid || result.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign query.ready = rdy1;

  // ---------------- stage 1: segment search
  logic   found;
  idx_t   lo_c, hi_c;
  mach_t  d_c;
  recip_t r_c;

  always_comb begin
    found = 1'b0;
    lo_c  = '0;
    hi_c  = '0;
    d_c   = '0;
    r_c   = '0;
    // descending so the lowest matching segment, assigned last, wins
    for (int k = NUM_POINTS - 2; k >= 0; k--) begin
      if (query.mach >= BP_TAB[k] && query.mach <= BP_TAB[k+1]) begin
        found = 1'b1;
        lo_c  = IDX_W'(k);
        hi_c  = IDX_W'(k + 1);
        d_c   = query.mach - BP_TAB[k];
        r_c   = RECIP_TAB[k];
      end
    end
    if (!found && query.mach >= BP_TAB[0]) begin
      lo_c = IDX_W'(NUM_POINTS - 1);
      hi_c = IDX_W'(NUM_POINTS - 1);
    end
  end

  mach_t  d1;
  recip_t r1;
  idx_t   lo1, hi1;
  alpha_t a1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= query.valid;
    end
    if (rdy1) begin
      d1  <= d_c;
      r1  <= r_c;
      lo1 <= lo_c;
      hi1 <= hi_c;
      a1  <= query.attack_angle;
    end
  end

  // ---------------- stage 2: segment fraction, alpha squared, table reads
  logic [TP_W-1:0] tp;
  logic [TP_W:0]   tsum;

  assign tp   = TP_W'(d1) * TP_W'(r1);
  assign tsum = {1'b0, tp} + T_HALF;

  logic [T_W-1:0]            t2;
  logic signed [ASQ_W-1:0]   asq2;
  alpha_t                    a2;
  logic signed [LERP_W-1:0]  base2 [NUM_TABLES];
  logic signed [LERP_W-1:0]  diff2 [NUM_TABLES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2) begin
      t2   <= tsum[16 +: T_W];
      asq2 <= ASQ_W'(a1) * ASQ_W'(a1);
      a2   <= a1;
      for (int j = 0; j < NUM_TABLES; j++) begin
        base2[j] <= LERP_W'(COEF_TAB[j][lo1]);
        diff2[j] <= LERP_W'(COEF_TAB[j][hi1]) - LERP_W'(COEF_TAB[j][lo1]);
      end
    end
  end

  // ---------------- stage 3: linear interpolation of all tables
  logic signed [LP_W-1:0]   lp   [NUM_TABLES];
  logic signed [LP_W-1:0]   lpr  [NUM_TABLES];
  logic signed [LERP_W-1:0] lerp_c [NUM_TABLES];

  always_comb begin
    for (int j = 0; j < NUM_TABLES; j++) begin
      lp[j]     = LP_W'(diff2[j]) * LP_W'($signed({1'b0, t2}));
      lpr[j]    = (lp[j] + LERP_HALF) >>> 16;
      lerp_c[j] = base2[j] + lpr[j][LERP_W-1:0];
    end
  end

  logic signed [LERP_W-1:0] lerp3 [NUM_TABLES];
  logic signed [ASQ_W-1:0]  asq3;
  alpha_t                   a3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3) begin
      lerp3 <= lerp_c;
      asq3  <= asq2;
      a3    <= a2;
    end
  end

  // ---------------- stage 4: drag and lift products
  logic signed [DP_W-1:0]   drag_p4;
  logic signed [LF_W-1:0]   lift_p4;
  logic signed [LERP_W-1:0] cx0_4, mz_4, trim_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (rdy4) begin
      v4 <= v3;
    end
    if (rdy4) begin
      drag_p4 <= DP_W'(lerp3[TAB_CXA2]) * DP_W'(asq3);
      lift_p4 <= LF_W'(lerp3[TAB_CYA]) * LF_W'(a3);
      cx0_4   <= lerp3[TAB_CX0];
      mz_4    <= lerp3[TAB_MZ];
      trim_4  <= lerp3[TAB_TRIM];
    end
  end

  // ---------------- stage 5: rounding, drag sum, saturation
  logic signed [DP_W-1:0]     drag_rnd;
  logic signed [LF_W-1:0]     lift_rnd;
  logic signed [SAT_IN_W-1:0] drag_sum;

  assign drag_rnd = (drag_p4 + DRAG_HALF) >>> 24;
  assign lift_rnd = (lift_p4 + LIFT_HALF) >>> 12;
  assign drag_sum = $signed(drag_rnd[SAT_IN_W-1:0]) + SAT_IN_W'(cx0_4);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (rdy5) begin
      result.valid <= v4;
    end
    if (rdy5) begin
      result.drag_coeff   <= sat_out(drag_sum);
      result.lift_coeff   <= sat_out($signed(lift_rnd[SAT_IN_W-1:0]));
      result.moment_coeff <= sat_out(SAT_IN_W'(mz_4));
      result.trim_ratio   <= sat_out(SAT_IN_W'(trim_4));
    end
  end

endmodule
